// File: rtl/tslcs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the token sequence lcs length block
// no dependencies

package tslcs_pkg;

    localparam int MAX_LEN_DEF = 1024;   // default store depth per sequence
    localparam int TOK_W       = 16;     // token code width
    localparam int FUNC_W      = 2;      // selector width
    localparam int THR_W       = 7;      // threshold register width
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int SIM_SCALE   = 200;    // 2 * 100 percent

    localparam logic [THR_W-1:0]  THR_RESET    = 7'd70;

    localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE  = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_THRESHOLD = 1'b0;

    // status from the dynamic program engine
    typedef struct packed {
        logic busy;
        logic done;
    } dp_stat_t;

endpackage

// File: rtl/token_sequence_lcs_length.sv
`timescale 1ns / 1ps
// top level of the token sequence lcs length block: stream ports, register port,
// token memory and sequencing; depends on tslcs_pkg, tslcs_dp and tslcs_out

// Tokens are appended to sequence A (func 0) or sequence B (func 1), one input
// transaction per cycle, each store holding MAX_LEN tokens; a token that finds
// its store full is dropped and raises the overflow flag. A compute transaction
// (func 2) runs the lcs dynamic program over both sequences and returns one
// result transaction with the lcs length, both lengths, the similar flag
// (200*lcs > threshold*(lenA+lenB)) and the overflow flag, then empties both
// sequences and clears the overflow flag. func 3 is ignored. After a compute is
// taken, s_tready stays low while it runs: the score row lives in one memory with
// a single read port, walked one cell per cycle with a turnaround state per row,
// then a done state and the load of the output register; the walk is skipped when
// either sequence is empty, and the wait is longer while an earlier result still
// waits in the output register. The result shows on m_tvalid in the cycle after
// the load; appends are taken again from that cycle on, even if the result has
// not been taken yet. The threshold register (reset 70) sits at byte address 0; the
// user must write it only while the block is idle, not enforced by the block.

module token_sequence_lcs_length import tslcs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int DATA_W  = ((3 * LEN_W + 2 + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TOK_W-1:0]      s_tdata,   // [15:0] token_code
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // lcs, length_a, length_b, similar,
                                             // overflowed, zero fill to whole bytes
    // register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(2 * MAX_LEN);

    typedef enum logic [1:0] {T_IDLE, T_RUN, T_EMIT} state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] count_a_reg, count_a_next;
    logic [LEN_W-1:0] count_b_reg, count_b_next;
    logic             ovf_reg, ovf_next;
    logic [THR_W-1:0] thr_reg;

    // token memory: sequence A in the lower half, sequence B in the upper half
    logic [TOK_W-1:0]  tok_mem [2*MAX_LEN];
    logic [TOK_W-1:0]  tok_a_rd_reg;
    logic [TOK_W-1:0]  tok_b_rd_reg;
    logic              tok_we;
    logic [ADDR_W-1:0] tok_waddr;

    logic             in_xfer;
    logic             is_a;
    logic             is_b;
    logic             start;
    logic [LEN_W-1:0] a_idx;
    logic [LEN_W-1:0] b_idx;
    dp_stat_t         dp_stat;
    logic [LEN_W-1:0] lcs;
    logic             out_free;
    logic             out_load;

    // ---------------- register port ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DATA_W'(thr_reg) : '0;

    // ---------------- input decode ----------------
    assign s_tready = (state_reg == T_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign is_a     = in_xfer && (s_tuser == FUNC_APPEND_A);
    assign is_b     = in_xfer && (s_tuser == FUNC_APPEND_B);
    assign start    = in_xfer && (s_tuser == FUNC_COMPUTE);

    // a full store drops the token
    assign tok_we    = (is_a && count_a_reg != LEN_W'(MAX_LEN))
                    || (is_b && count_b_reg != LEN_W'(MAX_LEN));
    assign tok_waddr = is_a ? ADDR_W'(count_a_reg)
                            : ADDR_W'(ADDR_W'(MAX_LEN) + ADDR_W'(count_b_reg));

    always_ff @(posedge aclk) begin
        if (tok_we) begin
            tok_mem[tok_waddr] <= s_tdata;
        end
        tok_a_rd_reg <= tok_mem[ADDR_W'(a_idx)];
        tok_b_rd_reg <= tok_mem[ADDR_W'(ADDR_W'(MAX_LEN) + ADDR_W'(b_idx))];
    end

    // ---------------- lcs engine ----------------
    tslcs_dp #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .len_a   (count_a_reg),
        .len_b   (count_b_reg),
        .a_idx   (a_idx),
        .b_idx   (b_idx),
        .tok_a   (tok_a_rd_reg),
        .tok_b   (tok_b_rd_reg),
        .stat    (dp_stat),
        .lcs     (lcs)
    );

    // ---------------- result stage ----------------
    assign out_load = (state_reg == T_EMIT) && out_free;

    tslcs_out #(
        .LEN_W  (LEN_W),
        .DATA_W (DATA_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .lcs       (lcs),
        .len_a     (count_a_reg),
        .len_b     (count_b_reg),
        .threshold (thr_reg),
        .ovf       (ovf_reg),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------- sequencing ----------------
    always_comb begin
        state_next   = state_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ovf_next     = ovf_reg;
        case (state_reg)
            T_IDLE: begin
                if (is_a) begin
                    if (count_a_reg == LEN_W'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_a_next = LEN_W'(count_a_reg + 1'b1);
                    end
                end
                if (is_b) begin
                    if (count_b_reg == LEN_W'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_b_next = LEN_W'(count_b_reg + 1'b1);
                    end
                end
                if (start) begin
                    state_next = T_RUN;
                end
            end
            T_RUN: begin
                if (dp_stat.done) begin
                    state_next = T_EMIT;
                end
            end
            T_EMIT: begin
                // wait for the output register, then empty both sequences
                if (out_free) begin
                    count_a_next = '0;
                    count_b_next = '0;
                    ovf_next     = 1'b0;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            count_a_reg <= '0;
            count_b_reg <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ovf_reg     <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    // the engine only runs while the top level waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.busy |-> (state_reg == T_RUN || state_reg == T_EMIT))
        else $error("lcs engine busy outside a compute");

    // lcs never exceeds the shorter sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.done |-> (lcs <= count_a_reg && lcs <= count_b_reg))
        else $error("lcs longer than a sequence");

    // counts stay within the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_a_reg <= LEN_W'(MAX_LEN) && count_b_reg <= LEN_W'(MAX_LEN))
        else $error("sequence count beyond capacity");

    // a compute closes the input until its result is stored
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_tready)
        else $error("input open during compute");

    // a result is loaded only after the engine finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !dp_stat.busy || dp_stat.done || $past(dp_stat.done))
        else $error("result loaded while engine running");
`endif

endmodule

// File: rtl/tslcs_dp.sv
`timescale 1ns / 1ps
// lcs dynamic program engine: one score row in a synchronous memory, one cell per cycle
// plus a turnaround state per row; depends on tslcs_pkg; token reads are served by the top level token memory

module tslcs_dp import tslcs_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF,
    parameter int LEN_W   = $clog2(MAX_LEN + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [LEN_W-1:0] len_a,
    input  logic [LEN_W-1:0] len_b,
    output logic [LEN_W-1:0] a_idx,
    output logic [LEN_W-1:0] b_idx,
    input  logic [TOK_W-1:0] tok_a,
    input  logic [TOK_W-1:0] tok_b,
    output dp_stat_t         stat,
    output logic [LEN_W-1:0] lcs
);

    typedef enum logic [1:0] {S_IDLE, S_ROW, S_CELL, S_DONE} state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] i_reg, i_next;
    logic [LEN_W-1:0] j_reg, j_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] diag_reg, diag_next;
    logic [LEN_W-1:0] lcs_reg, lcs_next;

    logic [LEN_W-1:0] score_mem [MAX_LEN+1];
    logic [LEN_W-1:0] up_rd_reg;
    logic [LEN_W-1:0] rd_addr;
    logic             wr_en;

    logic             last_col;
    logic [LEN_W-1:0] up;
    logic [LEN_W-1:0] score_val;

    assign last_col = (j_reg == len_b);

    // next read address stays inside the row at the last column
    always_comb begin
        if (state_reg == S_CELL && !last_col) begin
            rd_addr = LEN_W'(j_reg + 1'b1);
            b_idx   = j_reg;
        end else begin
            rd_addr = LEN_W'(1);
            b_idx   = '0;
        end
    end

    assign a_idx = i_reg;

    // first row reads as zero, so the row needs no clearing pass
    assign up        = (i_reg == '0) ? '0 : up_rd_reg;
    assign score_val = (tok_a == tok_b) ? LEN_W'(diag_reg + 1'b1)
                                        : ((up > left_reg) ? up : left_reg);

    assign wr_en = (state_reg == S_CELL);

    always_ff @(posedge aclk) begin
        up_rd_reg <= score_mem[rd_addr];
        if (wr_en) begin
            score_mem[j_reg] <= score_val;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        left_next  = left_reg;
        diag_next  = diag_reg;
        lcs_next   = lcs_reg;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    i_next = '0;
                    if (len_a == '0 || len_b == '0) begin
                        lcs_next   = '0;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_ROW;
                    end
                end
            end
            S_ROW: begin
                j_next     = LEN_W'(1);
                left_next  = '0;
                diag_next  = '0;
                state_next = S_CELL;
            end
            S_CELL: begin
                left_next = score_val;
                diag_next = up;
                if (last_col) begin
                    if (LEN_W'(i_reg + 1'b1) == len_a) begin
                        lcs_next   = score_val;
                        state_next = S_DONE;
                    end else begin
                        i_next     = LEN_W'(i_reg + 1'b1);
                        state_next = S_ROW;
                    end
                end else begin
                    j_next = LEN_W'(j_reg + 1'b1);
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            left_reg  <= '0;
            diag_reg  <= '0;
            lcs_reg   <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            left_reg  <= left_next;
            diag_reg  <= diag_next;
            lcs_reg   <= lcs_next;
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign lcs       = lcs_reg;

endmodule

// File: rtl/tslcs_out.sv
`timescale 1ns / 1ps
// result stage: similarity compare and the output register of the result channel
// depends on tslcs_pkg

module tslcs_out import tslcs_pkg::*; #(
    parameter int LEN_W  = 11,
    parameter int DATA_W = ((3 * LEN_W + 2 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [LEN_W-1:0]  lcs,
    input  logic [LEN_W-1:0]  len_a,
    input  logic [LEN_W-1:0]  len_b,
    input  logic [THR_W-1:0]  threshold,
    input  logic              ovf,
    output logic              free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    localparam int PROD_W = LEN_W + 9;

    logic              valid_reg;
    logic [DATA_W-1:0] data_reg;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    logic              similar;

    // 200*lcs > threshold*(lenA+lenB), both sides exact
    assign lhs     = PROD_W'(lcs) * PROD_W'(SIM_SCALE);
    assign rhs     = PROD_W'(threshold) * (PROD_W'(len_a) + PROD_W'(len_b));
    assign similar = (lhs > rhs);

    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= DATA_W'({ovf, similar, len_b, len_a, lcs});
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for token_sequence_lcs_length: stream stimulus, result scoreboard,
// register writes and an in-bench lcs length predictor
// depends on tslcs_pkg and the token_sequence_lcs_length rtl

module tb_top;
    import tslcs_pkg::*;

    localparam int LEN_W  = $clog2(MAX_LEN_DEF + 1);
    localparam int RES_W  = 3 * LEN_W + 2;
    localparam int DATA_W = ((RES_W + 7) / 8) * 8;

    // selector value the block must ignore
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int IDLE_PCT   = 25;
    localparam int HOLD_LEN   = 400;   // receiver hold-off, in cycles
    localparam int SETTLE_CYC = 8;     // quiet cycles before a register write
    localparam int TAIL_CYC   = 50;

    // result transaction, lowest field in the lowest bits
    typedef struct packed {
        logic             overflowed;
        logic             similar;
        logic [LEN_W-1:0] length_b;
        logic [LEN_W-1:0] length_a;
        logic [LEN_W-1:0] lcs_len;
    } lcs_result_t;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [TOK_W-1:0]  token;
        bit                typed;
        lcs_result_t       res;
    } dir_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TOK_W-1:0]      s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [DATA_W-1:0]     m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [TOK_W-1:0] tok_store_a [MAX_LEN_DEF];
    logic [TOK_W-1:0] tok_store_b [MAX_LEN_DEF];
    int               len_a;
    int               len_b;
    bit               dropped;
    logic [THR_W-1:0] threshold_pct;

    lcs_result_t pending_results [$];
    dir_row_t    dir_rows [$];
    int          errors      = 0;
    int          items_sent  = 0;
    bit          no_idle     = 1'b0;
    int          hold_asked  = 0;
    int          hold_served = 0;
    int          hold_left   = 0;

    token_sequence_lcs_length dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #(64'd20_000_000);
        $display("FAILURE");
        $finish;
    end

    // one-row lcs dynamic program over the stored sequences
    function automatic lcs_result_t score_sequences();
        int          row [0:MAX_LEN_DEF];
        int          diag;
        int          up;
        int          nxt;
        lcs_result_t r;
        for (int j = 0; j <= len_b; j++)
            row[j] = 0;
        for (int i = 0; i < len_a; i++) begin
            diag = 0;
            for (int j = 1; j <= len_b; j++) begin
                up = row[j];
                if (tok_store_a[i] == tok_store_b[j-1])
                    nxt = diag + 1;
                else
                    nxt = (up > row[j-1]) ? up : row[j-1];
                diag   = up;
                row[j] = nxt;
            end
        end
        r.lcs_len    = LEN_W'(row[len_b]);
        r.length_a   = LEN_W'(len_a);
        r.length_b   = LEN_W'(len_b);
        r.similar    = (SIM_SCALE * row[len_b]) > (int'(threshold_pct) * (len_a + len_b));
        r.overflowed = dropped;
        return r;
    endfunction

    // advance the predictor by one accepted transaction, returns 1 when a result is due
    function automatic bit take_item(input logic [FUNC_W-1:0] f, input logic [TOK_W-1:0] tok,
                                     output lcs_result_t res);
        bit due;
        due = 1'b0;
        res = '0;
        case (f)
            FUNC_APPEND_A: begin
                if (len_a >= MAX_LEN_DEF) begin
                    dropped = 1'b1;
                end else begin
                    tok_store_a[len_a] = tok;
                    len_a++;
                end
            end
            FUNC_APPEND_B: begin
                if (len_b >= MAX_LEN_DEF) begin
                    dropped = 1'b1;
                end else begin
                    tok_store_b[len_b] = tok;
                    len_b++;
                end
            end
            FUNC_COMPUTE: begin
                res     = score_sequences();
                due     = 1'b1;
                len_a   = 0;
                len_b   = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
        return due;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic lcs_result_t mk_result(int lcs, int la, int lb, bit sim, bit ovf);
        lcs_result_t r;
        r.lcs_len    = LEN_W'(lcs);
        r.length_a   = LEN_W'(la);
        r.length_b   = LEN_W'(lb);
        r.similar    = sim;
        r.overflowed = ovf;
        return r;
    endfunction

    function automatic void add_row(logic [FUNC_W-1:0] f, logic [TOK_W-1:0] tok, bit typed,
                                    lcs_result_t res);
        dir_row_t d;
        d.func   = f;
        d.token  = tok;
        d.typed  = typed;
        d.res    = res;
        dir_rows = {dir_rows, d};
    endfunction

    // offer one input transaction, idling at random first; valid stays up for the next one
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [TOK_W-1:0] tok,
                             input bit typed, input lcs_result_t typed_res);
        lcs_result_t res;
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= tok;
        do @(posedge aclk); while (!s_tready);
        if (take_item(f, tok, res))
            pending_results = {pending_results, (typed ? typed_res : res)};
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    // stop offering and wait for every outstanding result, then let the block settle
    task automatic wait_results_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // two-phase register write; upper data bits are random and must be ignored
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        logic [APB_DATA_W-1:0] wd;
        wd            = $urandom;
        wd[THR_W-1:0] = thr;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_THRESHOLD, 2'b00};
        pwdata  <= wd;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        threshold_pct = thr;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // one random pair of sequences followed, most of the time, by a compute
    task automatic send_frame();
        logic [TOK_W-1:0] pal [4];
        logic [TOK_W-1:0] a_toks [$];
        logic [TOK_W-1:0] b_toks [$];
        int               kind;
        int               na;
        int               nb;
        int               pal_n;
        kind  = $urandom_range(9);
        pal_n = $urandom_range(1, 4);
        foreach (pal[k])
            pal[k] = TOK_W'($urandom);
        na = (kind == 9) ? $urandom_range(20, 48) : $urandom_range(0, 10);
        nb = $urandom_range(0, 10);
        // a small alphabet makes matches common; kind 0 uses free tokens
        for (int k = 0; k < na; k++)
            a_toks = {a_toks,
                      ((kind == 0) ? TOK_W'($urandom) : pal[$urandom_range(pal_n - 1)])};
        if (kind == 1) begin
            b_toks = a_toks;   // identical sequences, similar in most settings
        end else begin
            for (int k = 0; k < nb; k++)
                b_toks = {b_toks,
                          ((kind == 0) ? TOK_W'($urandom) : pal[$urandom_range(pal_n - 1)])};
        end
        while (a_toks.size() + b_toks.size() != 0) begin
            if ($urandom_range(19) == 0)
                send_item(FUNC_UNUSED, TOK_W'($urandom), 1'b0, '0);
            else if (b_toks.size() == 0 || (a_toks.size() != 0 && $urandom_range(1) == 1))
                send_item(FUNC_APPEND_A, a_toks.pop_front(), 1'b0, '0);
            else
                send_item(FUNC_APPEND_B, b_toks.pop_front(), 1'b0, '0);
        end
        // kind 8 leaves the tokens in place so the next frame extends them
        if (kind != 8)
            send_item(FUNC_COMPUTE, TOK_W'($urandom), 1'b0, '0);
    endtask

    // receiver ready, with random idling and a long hold-off on request
    always @(negedge aclk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        lcs_result_t want;
        lcs_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, got %h", $time,
                         m_tdata);
            end else begin
                want = pending_results.pop_front();
                got  = m_tdata[RES_W-1:0];
                check_field("lcs_len", 16'(want.lcs_len), 16'(got.lcs_len));
                check_field("length_a", 16'(want.length_a), 16'(got.length_a));
                check_field("length_b", 16'(want.length_b), 16'(got.length_b));
                check_field("similar", 16'(want.similar), 16'(got.similar));
                check_field("overflowed", 16'(want.overflowed), 16'(got.overflowed));
                check_field("zero fill", '0, 16'(m_tdata[DATA_W-1:RES_W]));
            end
        end
    end

    initial begin
        logic [TOK_W-1:0] pal [4];
        logic [THR_W-1:0] thr_plan [6];
        int               phase_end;

        len_a         = 0;
        len_b         = 0;
        dropped       = 1'b0;
        threshold_pct = THR_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // rewrite the reset value, with noise in the unused data bits
        write_threshold(THR_RESET);

        // directed part, threshold 70
        add_row(FUNC_COMPUTE,  16'h0000, 1'b1, mk_result(0, 0, 0, 1'b0, 1'b0));   // both empty
        add_row(FUNC_UNUSED,   16'hFFFF, 1'b0, '0);                               // ignored
        add_row(FUNC_COMPUTE,  16'hFFFF, 1'b1, mk_result(0, 0, 0, 1'b0, 1'b0));
        add_row(FUNC_APPEND_A, 16'h0000, 1'b0, '0);
        add_row(FUNC_APPEND_A, 16'hFFFF, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'hFFFF, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'h0000, 1'b0, '0);
        add_row(FUNC_COMPUTE,  16'h0000, 1'b0, '0);
        add_row(FUNC_APPEND_A, 16'h1234, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'h1234, 1'b0, '0);
        add_row(FUNC_COMPUTE,  16'h0000, 1'b1, mk_result(1, 1, 1, 1'b1, 1'b0));   // identical
        add_row(FUNC_APPEND_A, 16'hAAAA, 1'b0, '0);
        add_row(FUNC_APPEND_A, 16'h5555, 1'b0, '0);
        add_row(FUNC_UNUSED,   16'h5555, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'h5555, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'hAAAA, 1'b0, '0);
        add_row(FUNC_COMPUTE,  16'hAAAA, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'h8000, 1'b0, '0);
        add_row(FUNC_APPEND_B, 16'h0001, 1'b0, '0);
        add_row(FUNC_COMPUTE,  16'h0000, 1'b1, mk_result(0, 0, 2, 1'b0, 1'b0));   // A empty
        add_row(FUNC_APPEND_A, 16'h7FFF, 1'b0, '0);
        add_row(FUNC_COMPUTE,  16'h0000, 1'b1, mk_result(0, 1, 0, 1'b0, 1'b0));   // B empty
        foreach (dir_rows[r])
            send_item(dir_rows[r].func, dir_rows[r].token, dir_rows[r].typed, dir_rows[r].res);
        wait_results_drained();

        // store capacity: exactly full, overflow on A, overflow on B
        foreach (pal[k])
            pal[k] = TOK_W'($urandom);
        for (int k = 0; k < MAX_LEN_DEF; k++)
            send_item(FUNC_APPEND_A, pal[$urandom_range(3)], 1'b0, '0);
        for (int k = 0; k < 30; k++)
            send_item(FUNC_APPEND_B, pal[$urandom_range(3)], 1'b0, '0);
        send_item(FUNC_COMPUTE, TOK_W'($urandom), 1'b0, '0);
        for (int k = 0; k < MAX_LEN_DEF + 3; k++)
            send_item(FUNC_APPEND_A, TOK_W'($urandom), 1'b0, '0);
        for (int k = 0; k < 2; k++)
            send_item(FUNC_APPEND_B, TOK_W'($urandom), 1'b0, '0);
        send_item(FUNC_COMPUTE, TOK_W'($urandom), 1'b0, '0);
        for (int k = 0; k < MAX_LEN_DEF + 1; k++)
            send_item(FUNC_APPEND_B, pal[$urandom_range(3)], 1'b0, '0);
        send_item(FUNC_COMPUTE, TOK_W'($urandom), 1'b0, '0);
        send_item(FUNC_COMPUTE, TOK_W'($urandom), 1'b0, '0);   // flag must be clear again
        wait_results_drained();

        // random phases, one threshold each, written while the block is idle
        thr_plan  = '{7'd0, 7'd100, 7'd127, 7'd1, 7'd50, 7'd99};
        thr_plan[5] = THR_W'($urandom_range(0, 127));
        items_sent = 0;
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_plan[p]);
            no_idle   = (p == 1);   // one phase runs at full rate on both sides
            phase_end = items_sent + 92;
            while (items_sent < phase_end) begin
                send_frame();
                // long receiver hold-off while frames keep coming, so the block backs up
                if (p == 3 && hold_asked == 0)
                    hold_asked++;
            end
            wait_results_drained();
        end
        no_idle = 1'b0;

        repeat (TAIL_CYC) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/tslcs_pkg.sv
rtl/tslcs_dp.sv
rtl/tslcs_out.sv
rtl/token_sequence_lcs_length.sv
tb/sv/tb_top.sv
